// ===== hw/rtl/bspg_pkg.sv =====
// shared types and constants for the buffered step pulse generator
package bspg_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_ZERO  = 2'd3
  } cmd_t;

  localparam int COUNT_W     = 8;
  localparam int PHASE_W     = 8;
  localparam int POS_W       = 16;
  localparam int PULSE_BIT   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [PHASE_W-1:0] PHASE_FIRST = 8'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 8'd255;

  typedef struct packed {
    cmd_t               cmd;
    logic [PHASE_W-1:0] phase;
    logic               pop;
    logic [COUNT_W-1:0] count;
    logic               underrun;
    logic               push_accepted;
    logic               fifo_full;
    logic               fifo_empty;
  } work_t;

endpackage

// ===== hw/rtl/bspg_ram.sv =====
// generic single-write, single-read ram with registered read data
module bspg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bspg_front.sv =====
// front end: accepts words, runs the step count fifo and phase counter, classifies ticks
module bspg_front #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic signed [7:0]    in_step_count,
  input  logic                 q_full,
  output logic                 q_wr,
  output bspg_pkg::work_t      q_wdata
);

  import bspg_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               f_valid_r;
  work_t              rec_r, rec_nxt;
  logic               accept;
  logic               full, empty;
  logic               ram_we, ram_re;
  logic [COUNT_W-1:0] ram_rdata;
  cmd_t               cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign full     = (rd_ptr_r == ptr_inc(wr_ptr_r));
  assign empty    = (rd_ptr_r == wr_ptr_r);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    phase_nxt  = phase_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rec_nxt    = '0;
    rec_nxt.cmd   = cmd;
    rec_nxt.phase = phase_r;
    case (cmd)
      CMD_PUSH: begin
        if (!full) begin
          ram_we                = accept;
          wr_ptr_nxt            = ptr_inc(wr_ptr_r);
          rec_nxt.push_accepted = 1'b1;
        end
      end
      CMD_TICK: begin
        phase_nxt = phase_r + 1'b1;
        if (phase_r == PHASE_FIRST) begin
          if (empty) begin
            rec_nxt.underrun = 1'b1;
          end else begin
            ram_re      = accept;
            rd_ptr_nxt  = ptr_inc(rd_ptr_r);
            rec_nxt.pop = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        rd_ptr_nxt = wr_ptr_r;
      end
      default: begin
      end
    endcase
    rec_nxt.fifo_full  = (rd_ptr_nxt == ptr_inc(wr_ptr_nxt));
    rec_nxt.fifo_empty = (rd_ptr_nxt == wr_ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      phase_r   <= '0;
      f_valid_r <= 1'b0;
    end else if (accept) begin
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      phase_r   <= phase_nxt;
      f_valid_r <= 1'b1;
    end else if (q_wr) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r <= rec_nxt;
    end
  end

  bspg_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(in_step_count),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  // popped count comes from the ram read register, which loads at the same edge as rec_r
  always_comb begin
    q_wdata       = rec_r;
    q_wdata.count = ram_rdata;
  end

  assign q_wr = f_valid_r && !q_full;

endmodule

// ===== hw/rtl/bspg_queue.sv =====
// short work queue between front and back
module bspg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  bspg_pkg::work_t wdata,
  output logic            full,
  input  logic            rd,
  output bspg_pkg::work_t rdata,
  output logic            empty
);

  import bspg_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, tail_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = entries[head_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[tail_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) begin
        tail_r <= tail_r + 1'b1;
      end
      if (rd) begin
        head_r <= head_r + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bspg_back.sv =====
// back end: segment state, pulse and position, output register
module bspg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                dir_polarity,
  input  logic                q_empty,
  input  bspg_pkg::work_t     q_rdata,
  output logic                q_rd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_push_accepted,
  output logic                out_fifo_full,
  output logic                out_fifo_empty,
  output logic                out_pulse_level,
  output logic                out_dir_level,
  output logic                out_underrun,
  output logic signed [15:0]  out_position
);

  import bspg_pkg::*;

  logic [COUNT_W-1:0]   steps_r, steps_nxt;
  logic                 dir_r, dir_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 pulse_r, pulse_nxt;
  logic                 out_valid_r;
  logic                 acc_r, full_r, empty_r, under_r;
  logic                 take;
  logic [2*COUNT_W-1:0] prod;
  logic [POS_W-1:0]     steps_ext;

  assign take      = !q_empty && (!out_valid_r || !out_stall);
  assign q_rd      = take;
  assign prod      = q_rdata.phase * steps_r;
  assign steps_ext = POS_W'(steps_r);

  always_comb begin
    steps_nxt = steps_r;
    dir_nxt   = dir_r;
    pos_nxt   = pos_r;
    pulse_nxt = pulse_r;
    case (q_rdata.cmd)
      CMD_TICK: begin
        if (q_rdata.phase == PHASE_FIRST) begin
          if (q_rdata.pop) begin
            if (q_rdata.count[COUNT_W-1]) begin
              dir_nxt   = !dir_polarity;
              steps_nxt = 8'd0 - q_rdata.count;
            end else begin
              dir_nxt   = dir_polarity;
              steps_nxt = q_rdata.count;
            end
          end
          pulse_nxt = 1'b0;
        end else if (q_rdata.phase == PHASE_LAST) begin
          if (dir_r == dir_polarity) begin
            pos_nxt = pos_r + steps_ext;
          end else begin
            pos_nxt = pos_r - steps_ext;
          end
          if (steps_r != '0) begin
            pulse_nxt = 1'b1;
          end
        end else begin
          pulse_nxt = prod[PULSE_BIT];
        end
      end
      CMD_ZERO: begin
        pos_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      dir_r       <= 1'b1;
      pos_r       <= '0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        steps_r     <= steps_nxt;
        dir_r       <= dir_nxt;
        pos_r       <= pos_nxt;
        pulse_r     <= pulse_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r   <= q_rdata.push_accepted;
      full_r  <= q_rdata.fifo_full;
      empty_r <= q_rdata.fifo_empty;
      under_r <= q_rdata.underrun;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_push_accepted = acc_r;
  assign out_fifo_full     = full_r;
  assign out_fifo_empty    = empty_r;
  assign out_pulse_level   = pulse_r;
  assign out_dir_level     = dir_r;
  assign out_underrun      = under_r;
  assign out_position      = pos_r;

endmodule

// ===== hw/rtl/buffered_step_pulse_generator.sv =====
// top level of the buffered step pulse generator
//
// input channel (in_valid / in_stall) takes one command word per cycle while
// in_stall is low: push a signed step count, tick the 256-phase period, flush
// the count fifo or zero the position. every word gives exactly one result
// word on the output channel (out_valid / out_stall), in order.
// on its way to out_valid the word passes the front register (with the count
// ram read beside it), one work queue entry and the back output register.
// throughput is one word per cycle while out_stall is low.
// a 4-entry work queue sits between front and back.
// when the receiver stalls, the output register holds, the queue fills and
// then in_stall rises; nothing is lost.
// cfg_valid / cfg_ready writes the direction polarity; cfg_ready is always
// high and writes belong in idle periods.
// synchronous reset empties the fifo and queue, clears phase, position and
// pulse, and sets polarity and direction to 1. the count ram is not cleared.
module buffered_step_pulse_generator #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_dir_polarity,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [7:0]  in_step_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_push_accepted,
  output logic               out_fifo_full,
  output logic               out_fifo_empty,
  output logic               out_pulse_level,
  output logic               out_dir_level,
  output logic               out_underrun,
  output logic signed [15:0] out_position
);

  import bspg_pkg::*;

  logic  polarity_r;
  logic  q_wr, q_full, q_rd, q_empty;
  work_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      polarity_r <= cfg_dir_polarity;
    end
  end

  bspg_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_step_count(in_step_count),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  bspg_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .wdata(q_wdata),
    .full (q_full),
    .rd   (q_rd),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  bspg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .dir_polarity     (polarity_r),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_rd             (q_rd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_push_accepted(out_push_accepted),
    .out_fifo_full    (out_fifo_full),
    .out_fifo_empty   (out_fifo_empty),
    .out_pulse_level  (out_pulse_level),
    .out_dir_level    (out_dir_level),
    .out_underrun     (out_underrun),
    .out_position     (out_position)
  );

endmodule
